[rtl/core/gld_pkg.sv]
// Shared constants, payload types and sequencer states of the GF(p) dependency finder.
package gld_pkg;

	localparam int DIM      = 16;
	localparam int WORD_W   = 32;
	localparam int ROW_LEN  = 2 * DIM + 1;
	localparam int IDX_W    = $clog2(DIM);
	localparam int RCNT_W   = $clog2(DIM + 1);
	localparam int COL_W    = $clog2(ROW_LEN);
	localparam int ADDR_W   = $clog2(DIM * ROW_LEN);
	localparam int STEP_W   = $clog2(WORD_W);
	localparam logic [WORD_W-1:0] MODULUS_RST = 32'd65521;

	typedef struct packed {
		logic              req_type;
		logic [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic              dependent;
		logic [WORD_W-1:0] coefficient;
		logic [4:0]        coeff_index;
		logic [3:0]        pivot_index;
		logic              last;
	} res_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RED, S_PREP, S_X, S_RD, S_EGO, S_EWAIT, S_SCAN,
		S_ECHK, S_DIV, S_EMUL, S_NGO, S_NWAIT, S_DEP, S_IND
	} state_t;

endpackage

[rtl/core/gld_cell.sv]
// One word cell of the work row ring: parallel load or shift from its neighbor.
module gld_cell
	import gld_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [WORD_W-1:0] load_data,
	input  logic [WORD_W-1:0] shift_in,
	output logic [WORD_W-1:0] q
);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= load_data;
		end else if (ctl.shift) begin
			word_q <= shift_in;
		end
	end

	assign q = word_q;

endmodule

[rtl/core/gld_mulmod.sv]
// Bit-serial modular multiplier: (mult * addend) mod p, one multiplier bit per cycle.
module gld_mulmod
	import gld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] mult,
	input  logic [WORD_W-1:0] addend,
	input  logic [WORD_W-1:0] p,
	output logic              done,
	output logic [WORD_W-1:0] result
);

	logic [WORD_W-1:0] acc_q, mult_q, add_q;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q, done_q;
	logic [WORD_W:0]   dbl, dbl_r, sum, sum_r;

	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
		sum   = dbl_r + (mult_q[WORD_W-1] ? {1'b0, add_q} : '0);
		sum_r = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(WORD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			mult_q <= mult;
			add_q  <= addend;
		end else if (run_q) begin
			acc_q  <= sum_r[WORD_W-1:0];
			mult_q <= {mult_q[WORD_W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q) else $error("multiplier restarted while running");
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (acc_q < p || p == '0)) else $error("product not reduced");
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("double done");
`endif

endmodule

[rtl/core/gld_div.sv]
// Restoring divider: quotient and remainder, one quotient bit per cycle.
module gld_div
	import gld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quot,
	output logic [WORD_W-1:0] rem
);

	logic [WORD_W-1:0] rem_q, quo_q, div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q, done_q;
	logic [WORD_W:0]   trial;
	logic              qbit;

	always_comb begin
		trial = {rem_q, quo_q[WORD_W-1]};
		qbit  = (trial >= {1'b0, div_q});
		if (qbit) begin
			trial = trial - {1'b0, div_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(WORD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= trial[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q) else $error("divider restarted while running");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < div_q) else $error("remainder not below divisor");
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("double done");
`endif

endmodule

[rtl/core/gfp_linear_dependency_finder.sv]
// Top level: incremental Gaussian elimination over GF(p) with dependency tracking.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  command  | start, busy (beat: start&!busy) | req (req_t: req_type, value)
//  result   | result_strobe, one cycle    | result (res_t)
//  config   | modulus_valid/modulus_ready | modulus_data (modulus)
//
// An element beat is reduced mod p by one bit-serial multiply.
// The last element of a vector adds elimination: per stored row, 33 columns
// of one memory read and one bit-serial multiply each (on the shared unit),
// then a pivot scan, extended Euclid (a divide then a multiply per step)
// and a 33-column normalize, or 17 result beats. The worst case per vector
// (15 stored rows, a long Euclid run, then the normalize) is set by the one
// shared multiplier. Reset clears control state and reloads the default
// modulus only; the basis memory needs no clearing pass. The receiver
// cannot stall: results go out one per cycle.
module gfp_linear_dependency_finder
	import gld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              result_strobe,
	output res_t              result,
	input  logic              modulus_valid,
	output logic              modulus_ready,
	input  logic [WORD_W-1:0] modulus_data
);

	state_t state_q, state_d;

	logic [WORD_W-1:0] modulus_q, pe, one_mod;
	logic [IDX_W-1:0]  elem_cnt_q, row_q, piv_q, scan_piv;
	logic [RCNT_W-1:0] row_count_q, emit_q;
	logic [COL_W-1:0]  col_q;
	logic [WORD_W-1:0] x_q, u1_q, v1_q, u3_q, v3_q, mem_q;
	logic [IDX_W-1:0]  piv_mem [DIM];
	logic [WORD_W-1:0] basis_mem [DIM * ROW_LEN];
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              scan_found;

	// work row ring
	logic [WORD_W-1:0] work [ROW_LEN];
	logic [WORD_W-1:0] tail_val, norm_val, sub_val;
	cell_ctl_t         ctl [ROW_LEN];
	logic              shift_en;

	// shared units
	logic              eng_start, eng_done, div_start, div_done;
	logic [WORD_W-1:0] eng_mult, eng_add, eng_res, div_quot, div_rem;
	logic [WORD_W:0]   t1_wide, sub_wide;

	// modulus below two behaves as one
	assign pe      = (modulus_q < 32'd2) ? 32'd1 : modulus_q;
	assign one_mod = (pe == 32'd1) ? '0 : 32'd1;

	assign busy          = (state_q != S_IDLE);
	assign modulus_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
		end else if (modulus_valid && modulus_ready) begin
			modulus_q <= modulus_data;
		end
	end

	// first nonzero vector column
	always_comb begin
		scan_found = 1'b0;
		scan_piv   = '0;
		for (int j = DIM - 1; j >= 0; j--) begin
			if (work[j] != '0) begin
				scan_found = 1'b1;
				scan_piv   = IDX_W'(j);
			end
		end
	end

	// modular subtractions: w - product, and Euclid cofactor update
	assign sub_wide = {1'b0, work[0]} + {1'b0, pe} - {1'b0, eng_res};
	assign sub_val  = (work[0] >= eng_res) ? work[0] - eng_res : sub_wide[WORD_W-1:0];
	assign t1_wide  = {1'b0, u1_q} + {1'b0, pe} - {1'b0, eng_res};
	assign norm_val = (col_q == COL_W'(piv_q)) ? 32'd1 : eng_res;
	assign tail_val = (state_q == S_NWAIT) ? norm_val : sub_val;

	assign rd_addr = ADDR_W'(row_q) * ADDR_W'(ROW_LEN) + ADDR_W'(col_q);
	assign wr_addr = ADDR_W'(row_count_q[IDX_W-1:0]) * ADDR_W'(ROW_LEN) + ADDR_W'(col_q);

	always_ff @(posedge clk) begin
		mem_q <= basis_mem[rd_addr];
		if (state_q == S_NWAIT && eng_done) begin
			basis_mem[wr_addr] <= norm_val;
		end
	end

	// next state and unit control
	always_comb begin
		state_d   = state_q;
		eng_start = 1'b0;
		eng_mult  = req.value;
		eng_add   = one_mod;
		div_start = 1'b0;
		shift_en  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start && req.req_type) begin
					eng_start = 1'b1;
					state_d   = S_RED;
				end
			end
			S_RED: begin
				if (eng_done) begin
					state_d = (elem_cnt_q == IDX_W'(DIM - 1)) ? S_PREP : S_IDLE;
				end
			end
			S_PREP: begin
				state_d = (row_count_q == '0) ? S_SCAN : S_X;
			end
			S_X:  state_d = S_RD;
			S_RD: state_d = S_EGO;
			S_EGO: begin
				eng_start = 1'b1;
				eng_mult  = mem_q;
				eng_add   = x_q;
				state_d   = S_EWAIT;
			end
			S_EWAIT: begin
				if (eng_done) begin
					shift_en = 1'b1;
					if (col_q == COL_W'(ROW_LEN - 1)) begin
						state_d = ({1'b0, row_q} + 1'b1 == row_count_q) ? S_SCAN : S_X;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_SCAN: begin
				if (!scan_found || row_count_q == RCNT_W'(DIM)) begin
					state_d = S_DEP;
				end else begin
					state_d = S_ECHK;
				end
			end
			S_ECHK: begin
				if (v3_q == '0) begin
					state_d = S_NGO;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					eng_start = 1'b1;
					eng_mult  = div_quot;
					eng_add   = v1_q;
					state_d   = S_EMUL;
				end
			end
			S_EMUL: begin
				if (eng_done) begin
					state_d = S_ECHK;
				end
			end
			S_NGO: begin
				eng_start = 1'b1;
				eng_mult  = work[0];
				eng_add   = u1_q;
				state_d   = S_NWAIT;
			end
			S_NWAIT: begin
				if (eng_done) begin
					shift_en = 1'b1;
					state_d  = (col_q == COL_W'(ROW_LEN - 1)) ? S_IND : S_NGO;
				end
			end
			S_DEP: begin
				if (emit_q == RCNT_W'(DIM)) begin
					state_d = S_IDLE;
				end
			end
			S_IND:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q  <= '0;
			row_count_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
			emit_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// clear request: drop the basis and any partial vector
					if (start && !req.req_type) begin
						elem_cnt_q  <= '0;
						row_count_q <= '0;
					end
				end
				S_RED: begin
					if (eng_done) begin
						elem_cnt_q <= elem_cnt_q + 1'b1;
					end
				end
				S_PREP: begin
					row_q <= '0;
					col_q <= '0;
				end
				S_EWAIT: begin
					if (eng_done) begin
						if (col_q == COL_W'(ROW_LEN - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				S_SCAN: begin
					col_q  <= '0;
					emit_q <= '0;
				end
				S_NWAIT: begin
					if (eng_done) begin
						if (col_q == COL_W'(ROW_LEN - 1)) begin
							col_q       <= '0;
							row_count_q <= row_count_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				S_DEP:   emit_q <= emit_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_X: x_q <= work[COL_W'(piv_mem[row_q])];
			S_SCAN: begin
				piv_q <= scan_piv;
				u1_q  <= 32'd1;
				v1_q  <= '0;
				u3_q  <= work[COL_W'(scan_piv)];
				v3_q  <= pe;
			end
			S_EMUL: begin
				if (eng_done) begin
					u1_q <= v1_q;
					v1_q <= (u1_q >= eng_res) ? u1_q - eng_res : t1_wide[WORD_W-1:0];
					u3_q <= v3_q;
					v3_q <= div_rem;
				end
			end
			S_NWAIT: begin
				if (eng_done && col_q == COL_W'(ROW_LEN - 1)) begin
					piv_mem[row_count_q[IDX_W-1:0]] <= piv_q;
				end
			end
			default: ;
		endcase
	end

	// ring cells: load on element entry and vector prep, rotate per column
	for (genvar i = 0; i < ROW_LEN; i++) begin : g_cell
		logic [WORD_W-1:0] ld_data;
		logic [WORD_W-1:0] sh_in;
		if (i < DIM) begin : g_vec
			assign ctl[i].load = (state_q == S_RED) && eng_done &&
				(elem_cnt_q == IDX_W'(i));
			assign ld_data = eng_res;
		end else begin : g_aug
			assign ctl[i].load = (state_q == S_PREP);
			assign ld_data = (row_count_q == RCNT_W'(i - DIM)) ? one_mod : '0;
		end
		if (i == ROW_LEN - 1) begin : g_tail
			assign sh_in = tail_val;
		end else begin : g_mid
			assign sh_in = work[i + 1];
		end
		assign ctl[i].shift = shift_en;

		gld_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.load_data (ld_data),
			.shift_in  (sh_in),
			.q         (work[i])
		);
	end

	gld_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.mult   (eng_mult),
		.addend (eng_add),
		.p      (pe),
		.done   (eng_done),
		.result (eng_res)
	);

	gld_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (u3_q),
		.divisor  (v3_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// result beats
	always_comb begin
		result_strobe      = (state_q == S_DEP) || (state_q == S_IND);
		result.dependent   = (state_q == S_DEP);
		result.coefficient = '0;
		result.coeff_index = '0;
		result.pivot_index = '0;
		result.last        = 1'b1;
		if (state_q == S_DEP) begin
			result.coefficient = work[COL_W'(DIM) + COL_W'(emit_q)];
			result.coeff_index = 5'(emit_q);
			result.last        = (emit_q == RCNT_W'(DIM));
		end else begin
			result.pivot_index = 4'(piv_q);
		end
	end

`ifndef SYNTHESIS
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy) else $error("result beat while idle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |=> !busy) else $error("busy after last beat");
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_count_q <= RCNT_W'(DIM)) else $error("row count overflow");
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NGO) |-> row_count_q < RCNT_W'(DIM)) else $error("store into full basis");
`endif

endmodule
